>>> hdl/slps_pkg.sv
package slps_pkg;

    localparam int unsigned STATUS_W = 32;
    localparam int unsigned REMAIN_W = 11;

    localparam logic [4:0] ERROR_BIT = 5'd0;
    localparam logic [4:0] LINK_BIT  = 5'd1;
    localparam logic [4:0] INPUT_BIT = 5'd2;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] PAT_FAST  = 2'd0;
    localparam logic [1:0] PAT_HEART = 2'd1;
    localparam logic [1:0] PAT_SOLID = 2'd2;
    localparam logic [1:0] PAT_ERROR = 2'd3;

    typedef struct packed {
        logic                valid;
        logic [1:0]          operation;
        logic [STATUS_W-1:0] bits;
    } slps_beat_t;

    typedef struct packed {
        logic                led;
        logic [STATUS_W-1:0] status_word;
        logic [1:0]          pattern;
    } slps_result_t;

    function automatic logic [1:0] seg_count_m1(input logic [1:0] pat);
        logic [1:0] n;
        unique case (pat)
            PAT_FAST:  n = 2'd1;
            PAT_HEART: n = 2'd1;
            PAT_SOLID: n = 2'd0;
            PAT_ERROR: n = 2'd3;
            default:   n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [REMAIN_W-1:0] seg_len(input logic [1:0] pat,
                                                    input logic [1:0] seg);
        logic [REMAIN_W-1:0] len;
        len = '0;
        unique case (pat)
            PAT_FAST:  len = (seg < 2'd2) ? 11'd30 : 11'd0;
            PAT_HEART:
            begin
                unique case (seg)
                    2'd0:    len = 11'd50;
                    2'd1:    len = 11'd1950;
                    default: len = 11'd0;
                endcase
            end
            PAT_SOLID: len = (seg == 2'd0) ? 11'd200 : 11'd0;
            PAT_ERROR:
            begin
                unique case (seg)
                    2'd0:    len = 11'd100;
                    2'd1:    len = 11'd400;
                    2'd2:    len = 11'd100;
                    default: len = 11'd1000;
                endcase
            end
            default:   len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [1:0] choose_pattern(input logic [STATUS_W-1:0] s);
        logic [1:0] p;
        priority if (s[ERROR_BIT])
            p = PAT_ERROR;
        else if (s[LINK_BIT] && s[INPUT_BIT])
            p = PAT_SOLID;
        else if (s[LINK_BIT])
            p = PAT_HEART;
        else
            p = PAT_FAST;
        return p;
    endfunction

endpackage

>>> hdl/slps_if.sv
interface slps_in_if import slps_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [STATUS_W-1:0] bits;

    modport source (output valid, output operation, output bits, input ready);
    modport sink (input valid, input operation, input bits, output ready);
endinterface

interface slps_out_if import slps_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                led;
    logic [STATUS_W-1:0] status_word;
    logic [1:0]          pattern;

    modport source (output valid, output led, output status_word, output pattern,
                    input ready);
    modport sink (input valid, input led, input status_word, input pattern,
                  output ready);
endinterface

>>> hdl/slps_in_stage.sv
module slps_in_stage import slps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slps_in_if.sink     cmd,
    input  logic        advance,
    output slps_beat_t  beat
);

    logic                valid_reg;
    logic                valid_next;
    logic [1:0]          operation_reg;
    logic [STATUS_W-1:0] bits_reg;
    logic                take;

    assign cmd.ready = !valid_reg || advance;
    assign take      = cmd.valid && cmd.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            operation_reg <= cmd.operation;
            bits_reg      <= cmd.bits;
        end
    end

    assign beat.valid     = valid_reg;
    assign beat.operation = operation_reg;
    assign beat.bits      = bits_reg;

endmodule

>>> hdl/slps_core.sv
module slps_core import slps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  slps_beat_t   beat,
    output slps_result_t result
);

    logic [STATUS_W-1:0] word_reg;
    logic [STATUS_W-1:0] word_next;
    logic [1:0]          pattern_reg;
    logic [1:0]          pattern_next;
    logic [1:0]          index_reg;
    logic [1:0]          index_next;
    logic [REMAIN_W-1:0] remain_reg;
    logic [REMAIN_W-1:0] remain_next;
    logic                led_reg;
    logic                led_next;
    logic [1:0]          seg;
    logic [1:0]          cur_seg;

    always_comb
    begin
        word_next    = word_reg;
        pattern_next = pattern_reg;
        index_next   = index_reg;
        remain_next  = remain_reg;
        led_next     = led_reg;
        seg          = '0;
        unique case (beat.operation)
            OP_TICK:
            begin
                if (remain_reg == '0)
                begin
                    if (index_reg == 2'd0)
                    begin
                        pattern_next = choose_pattern(word_reg);
                        index_next   = seg_count_m1(pattern_next);
                    end
                    else
                    begin
                        index_next = index_reg - 2'd1;
                    end
                    seg         = seg_count_m1(pattern_next) - index_next;
                    remain_next = seg_len(pattern_next, seg) - 11'd1;
                    led_next    = !seg[0];
                end
                else
                begin
                    remain_next = remain_reg - 11'd1;
                end
            end
            OP_SET:   word_next = word_reg | beat.bits;
            OP_CLEAR: word_next = word_reg & ~beat.bits;
            default:  word_next = word_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg    <= '0;
            pattern_reg <= PAT_FAST;
            index_reg   <= 2'd0;
            remain_reg  <= '0;
            led_reg     <= 1'b0;
        end
        else if (step)
        begin
            word_reg    <= word_next;
            pattern_reg <= pattern_next;
            index_reg   <= index_next;
            remain_reg  <= remain_next;
            led_reg     <= led_next;
        end
    end

    assign result.led         = led_reg;
    assign result.status_word = word_reg;
    assign result.pattern     = pattern_reg;

    assign cur_seg = seg_count_m1(pattern_reg) - index_reg;

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= seg_count_m1(pattern_reg))
        else $error("segment index beyond pattern length");

    a_remain_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
        remain_reg < seg_len(pattern_reg, cur_seg))
        else $error("remaining time exceeds segment length");

    a_solid_is_on: assert property (@(posedge clk) disable iff (!rst_n)
        (pattern_reg == PAT_SOLID) |-> led_reg)
        else $error("solid pattern with led off");

    a_set_applies: assert property (@(posedge clk) disable iff (!rst_n)
        (step && beat.operation == OP_SET) |=>
        ((word_reg & $past(beat.bits)) == $past(beat.bits)))
        else $error("set mask not applied");

    a_mask_keeps_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (step && beat.operation != OP_TICK) |=>
        ($stable(pattern_reg) && $stable(remain_reg) && $stable(led_reg)))
        else $error("pattern changed on a mask beat");

endmodule

>>> hdl/status_led_pattern_sequencer.sv
// status led pattern sequencer
// cmd channel: one beat per item; operation selects a 1 ms tick, a set of
// status bits (or mask) or a clear of status bits (and-not mask); operation
// three changes nothing. bits is ignored on a tick.
// report channel: exactly one beat per cmd beat, in order, carrying the led
// level, the status word and the pattern running after that item.
// a cmd beat is captured in the input register and applied to the core when
// report can advance, so results are two register stages behind the input.
// throughput: one item per cycle; a new cmd beat is taken in the same cycle
// a report beat leaves, as long as report is ready.
// when report stalls the result holds and one more cmd beat is buffered in
// the input register; cmd.ready then drops until report is taken.
// patterns: error 100 on, 400 off, 100 on, 1000 off; link and input set:
// solid 200 on; link alone: 50 on, 1950 off; otherwise 30 on, 30 off.
// a new status word is only looked at when the running pattern ends.
// reset: status word zero, fast blink, pattern counted as finished, led off;
// both channels empty, so the first tick samples the status word at once.
module status_led_pattern_sequencer import slps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    slps_in_if.sink     cmd,
    slps_out_if.source  report
);

    slps_beat_t   beat;
    slps_result_t result;
    logic         advance;
    logic         step;
    logic         out_valid_reg;
    logic         out_valid_next;

    assign advance = !out_valid_reg || report.ready;
    assign step    = advance && beat.valid;

    slps_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .advance (advance),
        .beat    (beat)
    );

    slps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .beat   (beat),
        .result (result)
    );

    assign out_valid_next = advance ? beat.valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign report.valid       = out_valid_reg;
    assign report.led         = result.led;
    assign report.status_word = result.status_word;
    assign report.pattern     = result.pattern;

endmodule

>>> sim/status_led_pattern_sequencer_tb.sv
`timescale 1ns / 1ps

module status_led_pattern_sequencer_tb;
    import slps_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned QUIET_LIMIT  = 3000;
    localparam int unsigned PHASE_ITEMS  = 375;
    localparam logic [1:0]  OP_NOP       = 2'd3;

    typedef struct packed {
        logic [1:0]          op;
        logic [STATUS_W-1:0] mask;
    } cmd_item_t;

    logic clk;
    logic rst_n;

    slps_in_if  cmd_bus ();
    slps_out_if rpt_bus ();

    status_led_pattern_sequencer u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .report (rpt_bus)
    );

    cmd_item_t    pending_cmds[$];
    slps_result_t expected_reports[$];
    cmd_item_t    next_cmd;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned cmds_offered;
    int unsigned cmds_taken;
    int unsigned quiet_cycles;
    int unsigned hold_left;
    int unsigned error_count;
    bit          cmd_fired;
    bit          hold_trigger;
    bit          hold_seen;

    // predictor state
    logic [STATUS_W-1:0] led_status;
    logic [1:0]          led_pattern;
    logic [1:0]          led_segs_left;
    logic [REMAIN_W-1:0] led_ms_left;
    logic                led_level;

    function automatic logic [1:0] segment_total(input logic [1:0] pat);
        case (pat)
            PAT_ERROR: return 2'd0;
            PAT_SOLID: return 2'd1;
            default:   return 2'd2;
        endcase
    endfunction

    function automatic logic [REMAIN_W-1:0] segment_length(input logic [1:0] pat,
                                                            input logic [1:0] seg);
        case (pat)
            PAT_FAST:  return 11'd30;
            PAT_HEART: return (seg == 2'd0) ? 11'd50 : 11'd1950;
            PAT_SOLID: return 11'd200;
            default:
            begin
                case (seg)
                    2'd0, 2'd2: return 11'd100;
                    2'd1:       return 11'd400;
                    default:    return 11'd1000;
                endcase
            end
        endcase
    endfunction

    function automatic logic [1:0] pick_pattern(input logic [STATUS_W-1:0] s);
        if (s[ERROR_BIT])
            return PAT_ERROR;
        if (s[LINK_BIT] && s[INPUT_BIT])
            return PAT_SOLID;
        if (s[LINK_BIT])
            return PAT_HEART;
        return PAT_FAST;
    endfunction

    function automatic slps_result_t advance_led_model(input logic [1:0] op,
                                                       input logic [STATUS_W-1:0] mask);
        slps_result_t res;
        logic [1:0]   seg;
        case (op)
            OP_TICK:
            begin
                if (led_ms_left == '0)
                begin
                    if (led_segs_left == 2'd0)
                    begin
                        led_pattern   = pick_pattern(led_status);
                        // total of four segments wraps to zero
                        led_segs_left = segment_total(led_pattern) - 2'd1;
                    end
                    else
                    begin
                        led_segs_left = led_segs_left - 2'd1;
                    end
                    seg         = segment_total(led_pattern) - 2'd1 - led_segs_left;
                    led_ms_left = segment_length(led_pattern, seg);
                    led_level   = ~seg[0];
                end
                if (led_ms_left != '0)
                    led_ms_left = led_ms_left - 1'b1;
            end
            OP_SET:   led_status = led_status | mask;
            OP_CLEAR: led_status = led_status & ~mask;
            default:  ;
        endcase
        res.led         = led_level;
        res.status_word = led_status;
        res.pattern     = led_pattern;
        return res;
    endfunction

    task automatic push_cmd(input logic [1:0] op, input logic [STATUS_W-1:0] mask);
        cmd_item_t c;
        c.op   = op;
        c.mask = mask;
        pending_cmds.push_back(c);
    endtask

    // mostly: set a chosen status word, then ticks; else random ops
    task automatic queue_random_items(input int unsigned n);
        int unsigned count;
        int unsigned r;
        int unsigned run;
        logic [STATUS_W-1:0] target;
        count = 0;
        while (count < n)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                target = $urandom;
                r = $urandom_range(99);
                if (r < 20)
                    target[ERROR_BIT] = 1'b1;
                else if (r < 55)
                    target[2:0] = 3'b110;
                else if (r < 70)
                    target[2:0] = 3'b010;
                else
                    target[1:0] = 2'b00;
                push_cmd(OP_CLEAR, ~target | $urandom);
                push_cmd(OP_SET, target);
                r = $urandom_range(99);
                if (r < 65)
                    run = $urandom_range(60, 1);
                else if (r < 93)
                    run = $urandom_range(250, 60);
                else
                    run = $urandom_range(700, 250);
                repeat (run)
                    push_cmd(OP_TICK, $urandom);
                count += run + 2;
            end
            else
            begin
                run = $urandom_range(5, 1);
                repeat (run)
                    push_cmd(2'($urandom_range(3)), $urandom);
                count += run;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (!(pending_cmds.size() == 0 && cmds_offered == cmds_taken &&
                 expected_reports.size() == 0));
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input bit with_hold);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random_items(PHASE_ITEMS);
        if (with_hold)
        begin
            repeat (20) @(posedge clk);
            hold_trigger = ~hold_trigger;
        end
        wait_drained();
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_bus.valid && !cmd_fired)
            begin
            end
            else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_cmd = pending_cmds.pop_front();
                cmds_offered++;
                cmd_bus.valid     <= 1'b1;
                cmd_bus.operation <= next_cmd.op;
                cmd_bus.bits      <= next_cmd.mask;
            end
            else
            begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // receiver with long hold-off
    always @(negedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rpt_bus.ready <= 1'b0;
        end
        else
        begin
            rpt_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        cmd_fired = 1'b0;
        if (rst_n)
        begin
            quiet_cycles++;
            if (cmd_bus.valid && cmd_bus.ready)
            begin
                expected_reports.push_back(advance_led_model(cmd_bus.operation,
                                                             cmd_bus.bits));
                cmds_taken++;
                cmd_fired    = 1'b1;
                quiet_cycles = 0;
            end
            if (rpt_bus.valid && rpt_bus.ready)
            begin
                quiet_cycles = 0;
                if (expected_reports.size() == 0)
                begin
                    error_count++;
                    $display("%0t unexpected report beat: led %0d status %h pattern %0d",
                             $time, rpt_bus.led, rpt_bus.status_word, rpt_bus.pattern);
                end
                else if (rpt_bus.led !== expected_reports[0].led ||
                         rpt_bus.status_word !== expected_reports[0].status_word ||
                         rpt_bus.pattern !== expected_reports[0].pattern)
                begin
                    error_count++;
                    $display("%0t mismatch: expected led %0d status %h pattern %0d",
                             $time, expected_reports[0].led,
                             expected_reports[0].status_word, expected_reports[0].pattern);
                    $display("%0t mismatch: actual   led %0d status %h pattern %0d",
                             $time, rpt_bus.led, rpt_bus.status_word, rpt_bus.pattern);
                    void'(expected_reports.pop_front());
                end
                else
                begin
                    void'(expected_reports.pop_front());
                end
            end
        end
    end

    // watchdog
    initial
    begin
        do
            @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("%0t timeout: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        cmd_bus.valid     = 1'b0;
        cmd_bus.operation = OP_TICK;
        cmd_bus.bits      = '0;
        rpt_bus.ready     = 1'b0;
        rst_n             = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        cmds_offered      = 0;
        cmds_taken        = 0;
        quiet_cycles      = 0;
        hold_left         = 0;
        error_count       = 0;
        cmd_fired         = 1'b0;
        hold_trigger      = 1'b0;
        hold_seen         = 1'b0;
        led_status        = '0;
        led_pattern       = PAT_FAST;
        led_segs_left     = 2'd0;
        led_ms_left       = '0;
        led_level         = 1'b0;

        // first tick after reset samples the status word at once
        push_cmd(OP_TICK, 32'hFFFF_FFFF);
        push_cmd(OP_NOP, 32'hFFFF_FFFF);
        push_cmd(OP_SET, 32'hFFFF_FFFF);
        push_cmd(OP_TICK, 32'h0000_0000);
        push_cmd(OP_CLEAR, 32'hFFFF_FFFF);
        push_cmd(OP_NOP, 32'h0000_0000);
        // set and clear mid-pattern do not disturb the running pattern
        push_cmd(OP_SET, 32'h0000_0007);
        push_cmd(OP_TICK, 32'h5555_5555);
        push_cmd(OP_CLEAR, 32'h0000_0001);
        push_cmd(OP_TICK, 32'hAAAA_AAAA);
        push_cmd(OP_SET, 32'h8000_0000);
        push_cmd(OP_CLEAR, 32'h7FFF_FFF8);
        push_cmd(OP_SET, 32'h0000_0001);
        push_cmd(OP_CLEAR, 32'h0000_0000);
        push_cmd(OP_SET, 32'h0000_0000);
        push_cmd(OP_TICK, 32'h0000_0000);
        push_cmd(OP_NOP, 32'h1234_5678);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_phase(0, 0, 1'b1);
        run_phase(68, 0, 1'b0);
        run_phase(0, 68, 1'b0);
        run_phase(30, 30, 1'b0);

        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
